@@ design/lgl_pkg.sv @@
// lgl_pkg: constants, types and step functions for the log-gamma pipeline
`timescale 1ns / 1ps
`default_nettype none
package lgl_pkg;

   // field widths
   localparam int unsigned ARG_W = 24;
   localparam int unsigned OUT_W = 28;

   // series terms and coefficients c1..c6 as Q.32 magnitudes
   localparam int unsigned TERMS = 6;
   localparam logic [32:0] C0_Q32 = 33'd4294967297;
   localparam logic [38:0] CK_MAG [TERMS] = '{
      39'd327191002584, 39'd371537521745, 39'd103139766587,
      39'd5290281181, 39'd5191116, 39'd23172
   };
   // set where the coefficient is negative (c2, c4, c6)
   localparam logic [TERMS-1:0] CK_NEG = 6'b101010;

   localparam logic [63:0] HALF_Q32  = 64'd2147483648;
   localparam logic [63:0] FIVE5_Q32 = 64'd23622320128;
   localparam logic [63:0] SQ2PI_Q32 = 64'd10765886463;
   localparam logic [63:0] LN2_Q32   = 64'd2977044472;

   localparam logic signed [OUT_W-1:0] OUT_MIN = -28'sd131072;
   localparam logic signed [OUT_W-1:0] OUT_MAX = 28'sd83886079;

   // series divider: 56-bit dividend, 25-bit divisor, 40 quotient bits
   localparam int unsigned SD_QW   = 40;
   localparam int unsigned SD_RW   = 25;
   localparam int unsigned SD_RQ_W = SD_RW + SD_QW;
   // ratio divider: 57-bit dividend, 24-bit divisor, 57 quotient bits
   localparam int unsigned RD_QW   = 57;
   localparam int unsigned RD_RW   = ARG_W;
   localparam int unsigned RD_RQ_W = RD_RW + RD_QW;

   // log unit
   localparam int unsigned NORM_STEPS = 6;
   localparam int unsigned SQ_STEPS   = 32;
   localparam int unsigned LN_W       = 40;
   localparam int unsigned SER_W      = 43;

   // stage positions along the pipe
   localparam int unsigned P_IN   = 0;
   localparam int unsigned P_SD   = P_IN + 1;
   localparam int unsigned P_SUMA = P_SD + SD_QW;
   localparam int unsigned P_SUMB = P_SUMA + 1;
   localparam int unsigned P_RPP  = P_SUMB + 1;
   localparam int unsigned P_RSUM = P_RPP + 1;
   localparam int unsigned P_N2   = P_RSUM + 1;
   localparam int unsigned P_RD   = P_N2 + 1;
   localparam int unsigned P_LOG  = P_RD + RD_QW;
   localparam int unsigned P_NORM = P_LOG + 1;
   localparam int unsigned P_SQ   = P_NORM + NORM_STEPS;
   localparam int unsigned P_MAG  = P_SQ + SQ_STEPS;
   localparam int unsigned P_LPP  = P_MAG + 1;
   localparam int unsigned P_LSUM = P_LPP + 1;
   localparam int unsigned P_PPP  = P_LSUM + 1;
   localparam int unsigned P_PSUM = P_PPP + 1;
   localparam int unsigned P_VSUM = P_PSUM + 1;
   localparam int unsigned P_OUT  = P_VSUM + 1;

   typedef struct packed {
      logic             valid;
      logic             zero;
      logic [ARG_W-1:0] x;
   } side_type;

   typedef struct packed {
      logic [63:0] hh;
      logic [63:0] hl;
      logic [63:0] lh;
      logic [63:0] lo;
   } pp_type;

   typedef struct packed {
      logic [63:0] v;
      logic [5:0]  cnt;
   } norm_type;

   typedef struct packed {
      logic [30:0] m;
      logic [31:0] frac;
      logic [5:0]  cnt;
   } sq_type;

   typedef struct packed {
      logic [37:0] mag;
      logic        neg;
   } mag_type;

   typedef struct packed {
      pp_type pp;
      logic   neg;
   } lpp_type;

   // q.32 product, first half: four 32 x 32 partial products
   function automatic pp_type mq_pp(input logic [63:0] a, input logic [63:0] b);
      pp_type pp;
      pp.hh = {32'b0, a[63:32]} * {32'b0, b[63:32]};
      pp.hl = {32'b0, a[63:32]} * {32'b0, b[31:0]};
      pp.lh = {32'b0, a[31:0]} * {32'b0, b[63:32]};
      pp.lo = {32'b0, a[31:0]} * {32'b0, b[31:0]};
      return pp;
   endfunction

   // q.32 product, second half: sum and round to nearest, halves up
   function automatic logic [63:0] mq_sum(input pp_type pp);
      return (pp.hh << 32) + pp.hl + pp.lh + {32'b0, pp.lo[63:32]}
             + {63'b0, pp.lo[31]};
   endfunction

   // divisor of series term idx+1
   function automatic logic [SD_RW-1:0] sd_den(input logic [ARG_W-1:0] x,
                                               input int unsigned idx);
      return {1'b0, x} + (SD_RW'(idx + 1) << 16);
   endfunction

   // rounded dividend of series term idx+1, zero-extended to the divider width
   function automatic logic [SD_RQ_W-1:0] sd_init(input logic [ARG_W-1:0] x,
                                                  input int unsigned idx);
      logic [SD_RW-1:0] den;
      logic [55:0]      n;
      den = sd_den(x, idx);
      n = {1'b0, CK_MAG[idx], 16'b0} + {32'b0, den[SD_RW-1:1]};
      return {9'b0, n};
   endfunction

   // one restoring step of the series divider
   function automatic logic [SD_RQ_W-1:0] sd_step(input logic [SD_RQ_W-1:0] rq,
                                                  input logic [SD_RW-1:0] den);
      logic [SD_RW:0]   tmp;
      logic [SD_RW:0]   dif;
      logic             qbit;
      logic [SD_RW-1:0] rem;
      tmp  = {rq[SD_RQ_W-1:SD_QW], rq[SD_QW-1]};
      dif  = tmp - {1'b0, den};
      qbit = (tmp >= {1'b0, den});
      rem  = qbit ? dif[SD_RW-1:0] : tmp[SD_RW-1:0];
      return {rem, rq[SD_QW-2:0], qbit};
   endfunction

   // one restoring step of the ratio divider
   function automatic logic [RD_RQ_W-1:0] rd_step(input logic [RD_RQ_W-1:0] rq,
                                                  input logic [RD_RW-1:0] den);
      logic [RD_RW:0]   tmp;
      logic [RD_RW:0]   dif;
      logic             qbit;
      logic [RD_RW-1:0] rem;
      tmp  = {rq[RD_RQ_W-1:RD_QW], rq[RD_QW-1]};
      dif  = tmp - {1'b0, den};
      qbit = (tmp >= {1'b0, den});
      rem  = qbit ? dif[RD_RW-1:0] : tmp[RD_RW-1:0];
      return {rem, rq[RD_QW-2:0], qbit};
   endfunction

   // one binary step of the leading-one search
   function automatic norm_type norm_step(input norm_type s, input int unsigned sh);
      norm_type r;
      r = s;
      if ((s.v >> (64 - sh)) == 64'd0) begin
         r.v   = s.v << sh;
         r.cnt = s.cnt + 6'(sh);
      end
      return r;
   endfunction

   // one squaring step: m = m*m >> 30, one log2 fraction bit out
   function automatic sq_type sq_step(input sq_type s);
      sq_type      r;
      logic [61:0] p;
      logic [31:0] hi;
      p  = s.m * s.m;
      hi = p[61:30];
      r.cnt = s.cnt;
      if (hi[31]) begin
         r.m    = hi[31:1];
         r.frac = {s.frac[30:0], 1'b1};
      end else begin
         r.m    = hi[30:0];
         r.frac = {s.frac[30:0], 1'b0};
      end
      return r;
   endfunction

   // log2 magnitude and sign from the leading-one count and fraction
   function automatic mag_type mag_form(input logic [5:0] cnt, input logic [31:0] frac);
      mag_type    r;
      logic [5:0] p;
      logic [5:0] whole;
      p = 6'd63 - cnt;
      whole = 6'd32 - p;
      if (p[5]) begin
         r.mag = {1'b0, p[4:0], frac};
         r.neg = 1'b0;
      end else begin
         r.mag = {whole, 32'b0} - {6'b0, frac};
         r.neg = 1'b1;
      end
      return r;
   endfunction

endpackage
`default_nettype wire

@@ design/log_gamma_lanczos_top.sv @@
// log_gamma_lanczos_top: pipelined ln gamma of a q8.16 argument by the lanczos series
//
// channel   ports                               dir   notes
// request   start, busy, req_arg_value[23:0]    in    word taken when start && !busy
// response  rsp_valid, rsp_log_gamma[27:0]      out   one-cycle strobe, q11.16 signed
//
// one word enters every clock cycle; busy stays low
// the strobe rises once the word has passed the whole pipe; the depth is set by
// the 40-step series dividers, the 57-step ratio divider and the 32 squaring steps of
// the log units, one step per stage
// synchronous reset clears the valid bits along the pipe only
// the receiver cannot stall, so words never wait inside the pipe
`timescale 1ns / 1ps
`default_nettype none
module log_gamma_lanczos_top (
   input  wire                              clock,
   input  wire                              reset,
   input  wire                              start,
   output logic                             busy,
   input  wire  [lgl_pkg::ARG_W-1:0]        req_arg_value,
   output logic                             rsp_valid,
   output logic signed [lgl_pkg::OUT_W-1:0] rsp_log_gamma
);
   import lgl_pkg::*;

   // sideband line: valid, zero flag and argument travel with each word
   side_type side_ff [P_VSUM+1];
   side_type side_in [P_VSUM+1];

   logic [SD_RQ_W-1:0] sd_ff [SD_QW][TERMS];
   logic [SD_RQ_W-1:0] sd_in [SD_QW][TERMS];

   logic [SER_W-1:0] sa_pos_ff, sa_pos_in;
   logic [SER_W-1:0] sa_neg_ff, sa_neg_in;
   logic [39:0]      sermag_ff, sermag_in;
   pp_type           rpp_ff, rpp_in;
   logic [39:0]      ratio_ff, ratio_in;
   logic [RD_QW-1:0] n2_ff, n2_in;

   logic [RD_RQ_W-1:0] rd_ff [RD_QW];
   logic [RD_RQ_W-1:0] rd_in [RD_QW];

   logic [63:0]            lg_v_ff [2];
   logic [63:0]            lg_v_in [2];
   norm_type               nm_ff [NORM_STEPS][2];
   norm_type               nm_in [NORM_STEPS][2];
   sq_type                 sq_ff [SQ_STEPS][2];
   sq_type                 sq_in [SQ_STEPS][2];
   mag_type                mag_ff [2];
   mag_type                mag_in [2];
   lpp_type                lpp_ff [2];
   lpp_type                lpp_in [2];
   logic [63:0]            ln_sum [2];
   logic signed [LN_W-1:0] ln_ff [2];
   logic signed [LN_W-1:0] ln_in [2];

   pp_type                 ppp_ff, ppp_in;
   logic signed [LN_W-1:0] lnr_d1_ff, lnr_d2_ff;
   logic [44:0]            prod_ff, prod_in;
   logic signed [47:0]     v_ff, v_in;

   logic                    rsp_valid_ff, rsp_valid_in;
   logic signed [OUT_W-1:0] rsp_log_gamma_ff, rsp_log_gamma_in;

   logic [63:0]        t_entry;
   logic [63:0]        ppp_a;
   logic [40:0]        t_final;
   logic signed [48:0] v_round;
   logic signed [32:0] r_q16;

   // the pipe never holds words off
   assign busy = 1'b0;

   // sideband line
   assign side_in[0].valid = start && !busy;
   assign side_in[0].zero  = (req_arg_value == '0);
   assign side_in[0].x     = req_arg_value;

   for (genvar i = 1; i <= P_VSUM; i++) begin : g_side
      assign side_in[i] = side_ff[i-1];
   end

   for (genvar i = 0; i <= P_VSUM; i++) begin : g_side_reg
      always_ff @(posedge clock) begin
         if (reset) begin
            side_ff[i].valid <= 1'b0;
         end else begin
            side_ff[i] <= side_in[i];
         end
      end
   end

   // six series dividers, one quotient bit per stage
   for (genvar j = 0; j < SD_QW; j++) begin : g_sd
      for (genvar k = 0; k < TERMS; k++) begin : g_term
         if (j == 0) begin : g_first
            assign sd_in[j][k] = sd_step(sd_init(side_ff[P_SD-1].x, k),
                                         sd_den(side_ff[P_SD-1].x, k));
         end else begin : g_next
            assign sd_in[j][k] = sd_step(sd_ff[j-1][k], sd_den(side_ff[P_SD+j-1].x, k));
         end
         always_ff @(posedge clock) begin
            sd_ff[j][k] <= sd_in[j][k];
         end
      end
   end

   // series sum, positive and negative terms apart
   always_comb begin
      sa_pos_in = SER_W'(C0_Q32);
      sa_neg_in = '0;
      for (int k = 0; k < TERMS; k++) begin
         if (CK_NEG[k]) begin
            sa_neg_in = sa_neg_in + SER_W'(sd_ff[SD_QW-1][k][SD_QW-1:0]);
         end else begin
            sa_pos_in = sa_pos_in + SER_W'(sd_ff[SD_QW-1][k][SD_QW-1:0]);
         end
      end
   end

   // series value, one lsb if not positive
   always_comb begin
      sermag_in = 40'd1;
      if (sa_pos_ff > sa_neg_ff) begin
         sermag_in = 40'(sa_pos_ff - sa_neg_ff);
      end
   end

   // sqrt(2 pi) * series, then the rounded dividend over x
   assign rpp_in   = mq_pp({24'b0, sermag_ff}, SQ2PI_Q32);
   assign ratio_in = 40'(mq_sum(rpp_ff));
   assign n2_in    = {1'b0, ratio_ff, 16'b0} + {34'b0, side_ff[P_N2-1].x[ARG_W-1:1]};

   always_ff @(posedge clock) begin
      sa_pos_ff <= sa_pos_in;
      sa_neg_ff <= sa_neg_in;
      sermag_ff <= sermag_in;
      rpp_ff    <= rpp_in;
      ratio_ff  <= ratio_in;
      n2_ff     <= n2_in;
   end

   // ratio divider by x
   for (genvar j = 0; j < RD_QW; j++) begin : g_rd
      if (j == 0) begin : g_first
         assign rd_in[j] = rd_step({{RD_RW{1'b0}}, n2_ff}, side_ff[P_RD-1].x);
      end else begin : g_next
         assign rd_in[j] = rd_step(rd_ff[j-1], side_ff[P_RD+j-1].x);
      end
      always_ff @(posedge clock) begin
         rd_ff[j] <= rd_in[j];
      end
   end

   // log operands: lane 0 is t = x + 5.5, lane 1 the ratio
   assign t_entry    = {24'b0, side_ff[P_LOG-1].x, 16'b0} + FIVE5_Q32;
   assign lg_v_in[0] = t_entry;
   assign lg_v_in[1] = (rd_ff[RD_QW-1][RD_QW-1:0] == '0) ? 64'd1
                       : {7'b0, rd_ff[RD_QW-1][RD_QW-1:0]};

   for (genvar ln = 0; ln < 2; ln++) begin : g_lane
      always_ff @(posedge clock) begin
         lg_v_ff[ln] <= lg_v_in[ln];
      end

      // leading-one search, halving the shift each stage
      for (genvar i = 0; i < NORM_STEPS; i++) begin : g_norm
         if (i == 0) begin : g_first
            assign nm_in[i][ln] = norm_step('{v: lg_v_ff[ln], cnt: 6'd0},
                                            1 << (NORM_STEPS - 1));
         end else begin : g_next
            assign nm_in[i][ln] = norm_step(nm_ff[i-1][ln], 1 << (NORM_STEPS - 1 - i));
         end
         always_ff @(posedge clock) begin
            nm_ff[i][ln] <= nm_in[i][ln];
         end
      end

      // squaring steps for the log2 fraction
      for (genvar i = 0; i < SQ_STEPS; i++) begin : g_sq
         if (i == 0) begin : g_first
            assign sq_in[i][ln] = sq_step('{m: nm_ff[NORM_STEPS-1][ln].v[63:33],
                                            frac: 32'd0,
                                            cnt: nm_ff[NORM_STEPS-1][ln].cnt});
         end else begin : g_next
            assign sq_in[i][ln] = sq_step(sq_ff[i-1][ln]);
         end
         always_ff @(posedge clock) begin
            sq_ff[i][ln] <= sq_in[i][ln];
         end
      end

      // log2 to natural log
      assign mag_in[ln]    = mag_form(sq_ff[SQ_STEPS-1][ln].cnt, sq_ff[SQ_STEPS-1][ln].frac);
      assign lpp_in[ln].pp  = mq_pp({26'b0, mag_ff[ln].mag}, LN2_Q32);
      assign lpp_in[ln].neg = mag_ff[ln].neg;
      assign ln_sum[ln] = mq_sum(lpp_ff[ln].pp);
      assign ln_in[ln] = lpp_ff[ln].neg ? -$signed({2'b0, ln_sum[ln][37:0]})
                                        : $signed({2'b0, ln_sum[ln][37:0]});

      always_ff @(posedge clock) begin
         mag_ff[ln] <= mag_in[ln];
         lpp_ff[ln] <= lpp_in[ln];
         ln_ff[ln]  <= ln_in[ln];
      end
   end

   // (x + 0.5) * ln t
   assign ppp_a   = {24'b0, side_ff[P_PPP-1].x, 16'b0} + HALF_Q32;
   assign ppp_in  = mq_pp(ppp_a, {{(64-LN_W){1'b0}}, ln_ff[0]});
   assign prod_in = 45'(mq_sum(ppp_ff));

   // prod - t + ln ratio
   assign t_final = {1'b0, side_ff[P_VSUM-1].x, 16'b0} + 41'(FIVE5_Q32);
   assign v_in    = $signed({3'b0, prod_ff}) - $signed({7'b0, t_final})
                    + 48'(lnr_d2_ff);

   always_ff @(posedge clock) begin
      ppp_ff    <= ppp_in;
      lnr_d1_ff <= ln_ff[1];
      prod_ff   <= prod_in;
      lnr_d2_ff <= lnr_d1_ff;
      v_ff      <= v_in;
   end

   // round to q.16, saturate, pole at zero
   assign v_round = 49'(v_ff) + 49'sd32768;
   assign r_q16   = v_round[48:16];

   always_comb begin
      rsp_valid_in = side_ff[P_VSUM].valid;
      if (side_ff[P_VSUM].zero) begin
         rsp_log_gamma_in = OUT_MAX;
      end else if (r_q16 < 33'(OUT_MIN)) begin
         rsp_log_gamma_in = OUT_MIN;
      end else if (r_q16 > 33'(OUT_MAX)) begin
         rsp_log_gamma_in = OUT_MAX;
      end else begin
         rsp_log_gamma_in = OUT_W'(r_q16);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_log_gamma_ff <= rsp_log_gamma_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_log_gamma = rsp_log_gamma_ff;

   // series stays positive for every argument
   a_ser_positive : assert property (@(posedge clock) disable iff (reset)
      side_ff[P_SUMA].valid |-> (sa_pos_ff > sa_neg_ff))
      else $error("lanczos series not positive");

   // leading-one search leaves the top bit set in both lanes
   a_norm_done : assert property (@(posedge clock) disable iff (reset)
      side_ff[P_SQ-1].valid |-> (nm_ff[NORM_STEPS-1][0].v[63]
                                 && nm_ff[NORM_STEPS-1][1].v[63]))
      else $error("log operand not normalised");

   // zero argument gives the top of the range at the output register
   a_pole : assert property (@(posedge clock) disable iff (reset)
      (side_ff[P_VSUM].valid && side_ff[P_VSUM].zero) |=>
      (rsp_valid && (rsp_log_gamma == OUT_MAX)))
      else $error("pole word not saturated high");

endmodule
`default_nettype wire

@@ dv/log_gamma_lanczos_top_test.sv @@
// testbench for the log-gamma pipeline: streamed arguments checked against a fixed-point predictor
`timescale 1ns / 1ps
`default_nettype none
module log_gamma_lanczos_top_test;
   import lgl_pkg::*;

   localparam int unsigned STALL_LIMIT = 2000;
   localparam int unsigned DRAIN_WAIT  = 200;
   localparam int unsigned RANDOM_ARGS = 1200;

   logic                    clock;
   logic                    reset;
   logic                    start;
   logic                    busy;
   logic [ARG_W-1:0]        req_arg_value;
   logic                    rsp_valid;
   logic signed [OUT_W-1:0] rsp_log_gamma;

   logic [ARG_W-1:0]        arg_queue[$];
   logic signed [OUT_W-1:0] lgamma_expected[$];
   int unsigned             idle_pct;
   int unsigned             phase;
   int unsigned             error_count = 0;
   int unsigned             words_in = 0;
   int unsigned             words_out = 0;
   int unsigned             quiet_cycles = 0;

   // lanczos coefficients c0..c6 in q.32
   localparam longint SERIES_COEF[7] = '{
      64'sd4294967297, 64'sd327191002584, -64'sd371537521745, 64'sd103139766587,
      -64'sd5290281181, 64'sd5191116, -64'sd23172
   };

   log_gamma_lanczos_top dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_arg_value(req_arg_value), .rsp_valid(rsp_valid), .rsp_log_gamma(rsp_log_gamma)
   );

   // clock
   initial clock = 1'b0;
   always #5 clock = ~clock;

   // q.32 product rounded to nearest, halves up
   function automatic logic [63:0] q32_product(input logic [63:0] a, input logic [63:0] b);
      logic [127:0] p;
      p = a * b;
      p = p + 128'h8000_0000;
      return p[95:32];
   endfunction

   // natural log of a positive q.32 value by repeated squaring
   function automatic longint q32_natural_log(input logic [63:0] v);
      int          p;
      logic [63:0] m;
      logic [63:0] frac;
      logic [63:0] mag;
      logic        neg;
      p = 63;
      frac = 0;
      if (v == 0) v = 1;
      while (p > 0 && v[p] == 1'b0) p--;
      if (p >= 30) m = v >> (p - 30);
      else m = v << (30 - p);
      for (int i = 0; i < 32; i++) begin
         m = (m * m) >> 30;
         if (m >= 64'h8000_0000) begin
            m = m >> 1;
            frac[31 - i] = 1'b1;
         end
      end
      if (p >= 32) begin
         mag = (64'(p - 32) << 32) + frac;
         neg = 1'b0;
      end else begin
         mag = (64'(32 - p) << 32) - frac;
         neg = 1'b1;
      end
      mag = q32_product(mag, LN2_Q32);
      return neg ? -longint'(mag) : longint'(mag);
   endfunction

   // ln gamma of one argument word, q11.16 saturated
   function automatic logic signed [OUT_W-1:0] lanczos_log_gamma(input logic [ARG_W-1:0] arg);
      logic [63:0]  x;
      logic [63:0]  den;
      logic [63:0]  cmag;
      logic [63:0]  q;
      logic [63:0]  sermag;
      logic [63:0]  t;
      logic [63:0]  prod;
      logic [127:0] ratio;
      longint       ser;
      longint       lnt;
      longint       lnr;
      longint       v;
      longint       r;
      x = 64'(arg);
      if (x == 0) return OUT_MAX;
      ser = SERIES_COEF[0];
      for (int k = 1; k <= 6; k++) begin
         cmag = SERIES_COEF[k] < 0 ? 64'(-SERIES_COEF[k]) : 64'(SERIES_COEF[k]);
         den  = x + (64'(k) << 16);
         q    = ((cmag << 16) + den / 2) / den;
         ser  = SERIES_COEF[k] < 0 ? ser - longint'(q) : ser + longint'(q);
      end
      sermag = ser > 0 ? 64'(ser) : 64'd1;
      t   = (x << 16) + FIVE5_Q32;
      lnt = q32_natural_log(t);
      prod = q32_product((x << 16) + HALF_Q32, 64'(lnt));
      ratio = 128'(q32_product(sermag, SQ2PI_Q32));
      ratio = ((ratio << 16) + x / 2) / x;
      lnr = q32_natural_log(ratio[63:0]);
      v = longint'(prod) - longint'(t) + lnr;
      r = v + 32768;
      r = r >>> 16;
      if (r < longint'(OUT_MIN)) r = OUT_MIN;
      if (r > longint'(OUT_MAX)) r = OUT_MAX;
      return OUT_W'(r);
   endfunction

   // request side: prediction taken at the rising edge that accepts the word
   always @(posedge clock) begin
      if (!reset && start && !busy) begin
         lgamma_expected.insert(lgamma_expected.size(), lanczos_log_gamma(req_arg_value));
         words_in <= words_in + 1;
      end
   end

   // word driver, changes at the falling edge
   always @(negedge clock) begin
      if (reset) begin
         start <= 1'b0;
         req_arg_value <= '0;
      end else begin
         if ((start && !busy) || !start) begin
            if (arg_queue.size() > 0 && $urandom_range(99) >= idle_pct) begin
               req_arg_value <= arg_queue.pop_front();
               start <= 1'b1;
            end else begin
               start <= 1'b0;
               req_arg_value <= ARG_W'($urandom);
            end
         end
      end
   end

   // result monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         words_out <= words_out + 1;
         if (lgamma_expected.size() == 0) begin
            error_count++;
            $display("%0t: unexpected result word %0d", $time, rsp_log_gamma);
         end else begin
            logic signed [OUT_W-1:0] want;
            want = lgamma_expected.pop_front();
            if (want !== rsp_log_gamma) begin
               error_count++;
               $display("%0t: log_gamma expected %0d actual %0d", $time, want, rsp_log_gamma);
            end
         end
      end
   end

   // watchdog on cycles with no traffic
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("watchdog expired with %0d results outstanding", lgamma_expected.size());
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // random argument: half small and mid values, half spanning the whole range
   function automatic logic [ARG_W-1:0] pick_arg();
      case ($urandom_range(3))
         0: return ARG_W'($urandom_range(1, 32'h0000_FFFF));
         1: return ARG_W'($urandom_range(32'h1_0000, 32'h0F_FFFF));
         2: return ARG_W'($urandom_range(1, 32'h00FF_FFFF));
         default: return ARG_W'($urandom) | ARG_W'(1 << $urandom_range(23));
      endcase
   endfunction

   // stimulus
   initial begin
      logic [ARG_W-1:0] directed[$];
      reset = 1'b1;
      idle_pct = 31;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // extremes: smallest, one half, x = 1 and its neighbours, x = 2, largest, zero pole
      directed = '{24'd1, 24'd2, 24'h00_8000, 24'h01_0000, 24'h02_0000, 24'h00_FFFF,
                   24'h01_0001, 24'h0A_0000, 24'h7F_FFFF, 24'h80_0000, 24'hAA_AAAA,
                   24'h55_5555, 24'hFF_FFFE, 24'hFF_FFFF, 24'd0, 24'h00_0100};
      foreach (directed[i]) arg_queue.insert(arg_queue.size(), directed[i]);

      for (phase = 0; phase < 3; phase++) begin
         idle_pct = (phase == 0) ? 31 : (phase == 1) ? 78 : 0;
         for (int i = 0; i < RANDOM_ARGS / 3; i++) arg_queue.insert(arg_queue.size(), pick_arg());
         while (arg_queue.size() > 0) @(posedge clock);
      end

      while (lgamma_expected.size() > 0 || start) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
      $display("checked %0d results from %0d argument words, from the pole at zero",
               words_out, words_in);
      $display("to the top of the range, under heavy, light and no request gaps");
      if (error_count == 0 && lgamma_expected.size() == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
`default_nettype wire
